FILE: sv/srs_pkg.sv
// shared types, constants and character tables of the s19 encoder
package srs_pkg;

    localparam int FILL_W = 6;
    localparam int ADDR_W = 16;

    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] KIND_S0     = 8'h30;
    localparam logic [7:0] KIND_S1     = 8'h31;
    localparam logic [7:0] KIND_S9     = 8'h39;
    localparam logic [7:0] HDR_COUNT   = 8'd19;
    localparam logic [7:0] S9_COUNT    = 8'd3;
    localparam logic [5:0] HDR_NBYTES  = 6'd19;
    localparam logic [5:0] S9_NBYTES   = 6'd3;
    localparam logic [5:0] REC_OVERHD  = 6'd3;
    localparam logic [1:0] CNT_PAIR    = 2'd2;
    localparam logic [1:0] CNT_SINGLE  = 2'd1;

    // operation of the shared pair unit
    typedef enum logic [1:0] {
        OP_HEAD,
        OP_BYTE,
        OP_CHK,
        OP_NL
    } op_code_t;

    typedef struct packed {
        op_code_t   op;
        logic [7:0] kind_char;
        logic [7:0] data;
    } pair_req_t;

    typedef struct packed {
        logic [15:0] text;
        logic [1:0]  count;
        logic        line_end;
    } pair_rsp_t;

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

    // header text of the s0 record
    function automatic logic [7:0] hdr_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:  c = 8'h43; // C
            4'd1:  c = 8'h6F; // o
            4'd2:  c = 8'h6E; // n
            4'd3:  c = 8'h76; // v
            4'd4:  c = 8'h65; // e
            4'd5:  c = 8'h72; // r
            4'd6:  c = 8'h74; // t
            4'd7:  c = 8'h65; // e
            4'd8:  c = 8'h64; // d
            4'd9:  c = 8'h20; // space
            4'd10: c = 8'h62; // b
            4'd11: c = 8'h69; // i
            4'd12: c = 8'h6E; // n
            4'd13: c = 8'h61; // a
            4'd14: c = 8'h72; // r
            4'd15: c = 8'h79; // y
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/srs_pair_unit.sv
// shared unit: running checksum and hex encoding of one character pair
module srs_pair_unit
    import srs_pkg::*;
(
    input  pair_req_t  req,
    input  logic [7:0] sum_in,
    output pair_rsp_t  rsp,
    output logic [7:0] sum_out
);

    logic [7:0] chk;

    assign chk = ~sum_in;

    // one pair per operation, or a lone newline for OP_NL
    always_comb begin
        rsp     = '0;
        sum_out = sum_in;
        unique case (req.op)
            OP_HEAD: begin
                rsp.text  = {CHAR_S, req.kind_char};
                rsp.count = CNT_PAIR;
                sum_out   = 8'h00;
            end
            OP_BYTE: begin
                rsp.text  = {hex_char(req.data[7:4]), hex_char(req.data[3:0])};
                rsp.count = CNT_PAIR;
                sum_out   = sum_in + req.data;
            end
            OP_CHK: begin
                rsp.text  = {hex_char(chk[7:4]), hex_char(chk[3:0])};
                rsp.count = CNT_PAIR;
            end
            OP_NL: begin
                rsp.text     = {CHAR_NL, 8'h00};
                rsp.count    = CNT_SINGLE;
                rsp.line_end = 1'b1;
            end
            default: begin
                rsp = '0;
            end
        endcase
    end

endmodule

FILE: sv/srecord_s19_encoder.sv
// top level of the s19 encoder: record sequencer, byte buffer and config register
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata data_byte, tuser has_data, tlast end_of_input
//  m_      | out | m_tvalid/m_tready  | tdata text_pair/char_count, tuser line_end, tlast last
//  apb     | in  | psel/penable       | start_address at byte address 0
//
// an item that causes no record is only accepted; else the sequencer emits one pair per
// cycle while m_tready does not stall, through the shared pair unit: the S and kind pair,
// byte pairs, checksum pair and a newline. s_tready is low while records are emitted.
// reset is synchronous, active low, and clears the sequencer and the header flag.
// a stall on m_tready holds the output register and the sequencer.
module srecord_s19_encoder
    import srs_pkg::*;
#(
    parameter int BYTES_PER_RECORD = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] has_data
    input  logic        s_tlast,   // end_of_input
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] text_pair, [17:16] char_count, zero above
    output logic [0:0]  m_tuser,   // [0] line_end
    output logic        m_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW        = (BYTES_PER_RECORD > 1) ? $clog2(BYTES_PER_RECORD) : 1;
    localparam int BUF_DEPTH = 2 ** IW;
    localparam logic [FILL_W-1:0] BPR_F = FILL_W'(BYTES_PER_RECORD);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;
    typedef enum logic [1:0] {PH_HEAD, PH_BYTE, PH_CHK, PH_NL} phase_t;
    typedef enum logic [1:0] {REC_S0, REC_S1, REC_S9} rec_t;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    rec_t                rec_reg, rec_next;
    logic [5:0]          idx_reg, idx_next;
    logic [7:0]          sum_reg, sum_next;
    logic                s1_pend_reg, s1_pend_next;
    logic                s9_pend_reg, s9_pend_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                hdr_done_reg, hdr_done_next;
    logic [ADDR_W-1:0]   start_reg, start_next;
    logic [15:0]         out_text_reg, out_text_next;
    logic [1:0]          out_cnt_reg, out_cnt_next;
    logic                out_le_reg, out_le_next;
    logic                out_last_reg, out_last_next;
    logic                out_valid_reg, out_valid_next;

    logic [7:0]          buf_mem [BUF_DEPTH];

    logic                s_accept, step, cfg_we;
    logic [FILL_W-1:0]   f0, f1;
    logic                full_flush, s1_due;
    logic [5:0]          idx_m3, n_bytes;
    logic [7:0]          cur_byte, kind_char;
    logic                has_next;
    rec_t                next_rec;
    pair_req_t           req;
    pair_rsp_t           rsp;
    logic [7:0]          unit_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign step     = (state_reg == ST_RUN) && (!out_valid_reg || m_tready);
    assign cfg_we   = psel && penable && pwrite && (paddr[2] == 1'b0);

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {16'h0000, start_reg} : 32'h0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_cnt_reg, out_text_reg};
    assign m_tuser  = out_le_reg;
    assign m_tlast  = out_last_reg;

    // fill after this item and whether an s1 record is due
    assign f0         = hdr_done_reg ? fill_reg : '0;
    assign f1         = s_tuser[0] ? (f0 + FILL_W'(1)) : f0;
    assign full_flush = s_tuser[0] && (f1 >= BPR_F);
    assign s1_due     = full_flush || (s_tlast && (f1 != '0));

    // byte of the current record at the current index
    assign idx_m3 = idx_reg - REC_OVERHD;
    always_comb begin
        cur_byte  = 8'h00;
        n_bytes   = S9_NBYTES;
        kind_char = KIND_S9;
        unique case (rec_reg)
            REC_S0: begin
                n_bytes   = HDR_NBYTES;
                kind_char = KIND_S0;
                priority if (idx_reg == 6'd0) begin
                    cur_byte = HDR_COUNT;
                end else if (idx_reg < REC_OVERHD) begin
                    cur_byte = 8'h00;
                end else begin
                    cur_byte = hdr_char(idx_m3[3:0]);
                end
            end
            REC_S1: begin
                n_bytes   = fill_reg + REC_OVERHD;
                kind_char = KIND_S1;
                priority if (idx_reg == 6'd0) begin
                    cur_byte = {2'b00, n_bytes};
                end else if (idx_reg == 6'd1) begin
                    cur_byte = addr_reg[15:8];
                end else if (idx_reg == 6'd2) begin
                    cur_byte = addr_reg[7:0];
                end else begin
                    cur_byte = buf_mem[idx_m3[IW-1:0]];
                end
            end
            REC_S9: begin
                priority if (idx_reg == 6'd0) begin
                    cur_byte = S9_COUNT;
                end else if (idx_reg == 6'd1) begin
                    cur_byte = start_reg[15:8];
                end else begin
                    cur_byte = start_reg[7:0];
                end
            end
            default: begin
                cur_byte = 8'h00;
            end
        endcase
    end

    // record that follows the current one
    always_comb begin
        has_next = 1'b0;
        next_rec = REC_S9;
        unique case (rec_reg)
            REC_S0: begin
                has_next = s1_pend_reg || s9_pend_reg;
                next_rec = s1_pend_reg ? REC_S1 : REC_S9;
            end
            REC_S1: begin
                has_next = s9_pend_reg;
            end
            default: begin
                has_next = 1'b0;
            end
        endcase
    end

    // request to the shared pair unit
    always_comb begin
        req.kind_char = kind_char;
        req.data      = cur_byte;
        unique case (phase_reg)
            PH_HEAD: req.op = OP_HEAD;
            PH_BYTE: req.op = OP_BYTE;
            PH_CHK:  req.op = OP_CHK;
            default: req.op = OP_NL;
        endcase
    end

    srs_pair_unit u_pair (
        .req     (req),
        .sum_in  (sum_reg),
        .rsp     (rsp),
        .sum_out (unit_sum)
    );

    // sequencer next state
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        rec_next       = rec_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        s1_pend_next   = s1_pend_reg;
        s9_pend_next   = s9_pend_reg;
        fill_next      = fill_reg;
        addr_next      = addr_reg;
        hdr_done_next  = hdr_done_reg;
        start_next     = cfg_we ? pwdata[15:0] : start_reg;
        out_text_next  = out_text_reg;
        out_cnt_next   = out_cnt_reg;
        out_le_next    = out_le_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        // accept: plan the records of this item
        if (s_accept) begin
            fill_next     = f1;
            s1_pend_next  = s1_due;
            s9_pend_next  = s_tlast;
            hdr_done_next = !s_tlast;
            if (!hdr_done_reg) begin
                addr_next = start_reg;
            end
            if (!hdr_done_reg || s1_due || s_tlast) begin
                state_next = ST_RUN;
                phase_next = PH_HEAD;
                priority if (!hdr_done_reg) begin
                    rec_next = REC_S0;
                end else if (s1_due) begin
                    rec_next = REC_S1;
                end else begin
                    rec_next = REC_S9;
                end
            end
        end

        // emit one pair or the newline
        if (step) begin
            out_valid_next = 1'b1;
            out_text_next  = rsp.text;
            out_cnt_next   = rsp.count;
            out_le_next    = rsp.line_end;
            out_last_next  = 1'b0;
            sum_next       = unit_sum;
            unique case (phase_reg)
                PH_HEAD: begin
                    phase_next = PH_BYTE;
                    idx_next   = 6'd0;
                end
                PH_BYTE: begin
                    if (idx_reg == n_bytes - 6'd1) begin
                        phase_next = PH_CHK;
                    end else begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                PH_CHK: begin
                    phase_next = PH_NL;
                end
                default: begin
                    out_last_next = !has_next;
                    if (rec_reg == REC_S1) begin
                        addr_next    = addr_reg + {{(ADDR_W-FILL_W){1'b0}}, fill_reg};
                        fill_next    = '0;
                        s1_pend_next = 1'b0;
                    end
                    if (rec_reg == REC_S9) begin
                        s9_pend_next = 1'b0;
                        fill_next    = '0;
                    end
                    if (has_next) begin
                        rec_next   = next_rec;
                        phase_next = PH_HEAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_HEAD;
            rec_reg       <= REC_S0;
            idx_reg       <= '0;
            s1_pend_reg   <= 1'b0;
            s9_pend_reg   <= 1'b0;
            fill_reg      <= '0;
            addr_reg      <= '0;
            hdr_done_reg  <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            rec_reg       <= rec_next;
            idx_reg       <= idx_next;
            s1_pend_reg   <= s1_pend_next;
            s9_pend_reg   <= s9_pend_next;
            fill_reg      <= fill_next;
            addr_reg      <= addr_next;
            hdr_done_reg  <= hdr_done_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
        sum_reg      <= sum_next;
        out_text_reg <= out_text_next;
        out_cnt_reg  <= out_cnt_next;
        out_le_reg   <= out_le_next;
        out_last_reg <= out_last_next;
    end

    // record buffer write
    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser[0]) begin
            buf_mem[f0[IW-1:0]] <= s_tdata;
        end
    end

endmodule

FILE: sv/srs_checker.sv
// port checker of the s19 encoder and its bind to the top level
module srs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result item changed");

    // a line end is a lone newline
    a_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[17:0] == {2'd1, 16'h0A00})
        else $error("line end without lone newline");

    // every other item carries two characters
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[17:16] == 2'd2)
        else $error("character pair with wrong count");

    // the final result of an item closes a record line
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("last result not at a line end");

endmodule

bind srecord_s19_encoder srs_checker u_srs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
